/* rtl/radius_neighbor_edge_list_top_defines.svh */
`ifndef RADIUS_NEIGHBOR_EDGE_LIST_TOP_DEFINES_SVH
`define RADIUS_NEIGHBOR_EDGE_LIST_TOP_DEFINES_SVH

// Same-cycle implication.
`define RNEL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RNEL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rnel_pkg.sv */
`default_nettype none

package rnel_pkg;

  localparam int MAX_ATOMS  = 64;
  localparam int AW         = $clog2(MAX_ATOMS);
  localparam int IDX_W      = 6;
  localparam int CNT_CAP    = (MAX_ATOMS < (1 << IDX_W)) ? MAX_ATOMS : (1 << IDX_W);
  localparam int CNT_W      = $clog2(CNT_CAP + 1);
  localparam int CMP_W      = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int CNT_REG_W  = 7;
  localparam int COORD_W    = 20;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int D2_W       = SQ_W + 2;
  localparam int RAD_W      = 21;
  localparam int LIM_W      = 2 * RAD_W;
  localparam int DIST_W     = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATOM_COUNT = 2'd1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_SCAN,
    ST_SQRT,
    ST_LAST,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic             row_ld;
    logic             vld;
    logic             kill;
    logic [IDX_W-1:0] col;
  } scan_ctl_t;

  typedef struct packed {
    logic             vld;
    logic             hit;
    logic             pend;
    logic [IDX_W-1:0] col;
    logic [D2_W-1:0]  d2;
  } scan_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

/* rtl/rnel_store.sv */
`default_nettype none

module rnel_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [rnel_pkg::AW-1:0]   waddr,
  input  rnel_pkg::point_t          wdata,
  input  logic                      re,
  input  logic [rnel_pkg::AW-1:0]   raddr,
  output rnel_pkg::point_t          rdata
);
  import rnel_pkg::*;

  point_t mem_r [MAX_ATOMS];
  point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/rnel_dist.sv */
`default_nettype none

module rnel_dist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rnel_pkg::scan_ctl_t          ctl,
  input  rnel_pkg::point_t             pt,
  input  logic [rnel_pkg::RAD_W-1:0]   radius,
  output rnel_pkg::scan_res_t          res
);
  import rnel_pkg::*;

  localparam int HW = (D2_W > LIM_W) ? D2_W : LIM_W;

  point_t             row_r;
  logic               v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]   c1_r, c2_r, c3_r;
  logic [COORD_W-1:0] ax_r, ay_r, az_r;
  logic [SQ_W-1:0]    sx_r, sy_r, sz_r;
  logic [LIM_W-1:0]   lim2_r;
  logic [D2_W-1:0]    d2;

  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (d[COORD_W]) begin
      d = -d;
    end
    return d[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ctl.kill) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctl.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: store read data; stage 2: |delta|; stage 3: squares
  always_ff @(posedge clk) begin
    if (ctl.row_ld) begin
      row_r <= pt;
    end
    c1_r   <= ctl.col;
    c2_r   <= c1_r;
    c3_r   <= c2_r;
    ax_r   <= abs_diff(row_r.x, pt.x);
    ay_r   <= abs_diff(row_r.y, pt.y);
    az_r   <= abs_diff(row_r.z, pt.z);
    sx_r   <= ax_r * ax_r;
    sy_r   <= ay_r * ay_r;
    sz_r   <= az_r * az_r;
    lim2_r <= radius * radius;
  end

  always_comb begin
    d2       = D2_W'(sx_r) + D2_W'(sy_r) + D2_W'(sz_r);
    res.vld  = v3_r;
    res.hit  = HW'(d2) <= HW'(lim2_r);
    res.pend = v1_r | v2_r | v3_r;
    res.col  = c3_r;
    res.d2   = d2;
  end

endmodule

`default_nettype wire

/* rtl/rnel_sqrt.sv */
`default_nettype none

module rnel_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rnel_pkg::D2_W-1:0]    rad,
  output rnel_pkg::sqrt_stat_t         stat,
  output logic [rnel_pkg::DIST_W-1:0]  root
);
  import rnel_pkg::*;

  localparam int TOP_BIT = ((D2_W - 1) / 2) * 2;

  logic [D2_W-1:0] v_r, res_r, bit_r;
  logic            busy_r, done_r;
  logic [D2_W:0]   trial;
  logic            ge;

  always_comb begin
    trial = {1'b0, res_r} + {1'b0, bit_r};
    ge    = {1'b0, v_r} >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= rad;
      res_r <= '0;
      bit_r <= D2_W'(1) << TOP_BIT;
    end else if (busy_r) begin
      if (ge) begin
        v_r   <= v_r - trial[D2_W-1:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = res_r[DIST_W-1:0];

endmodule

`default_nettype wire

/* rtl/radius_neighbor_edge_list_top.sv */
// Fixed-radius neighbor graph over up to 64 stored 3D points.
// Input channel (in_valid/in_ready): in_action load writes in_coord_x/y/z
// into slot in_atom_index and gives no result; in_action query names a row i.
// Result channel (out_valid/out_ready): for a query, one item per pair (i,j),
// j >= i in ascending order, whose squared distance is within radius squared,
// with the floor square-root distance; the final item of the row has
// out_is_last. A row not below atom_count gives one item with out_row_error.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 radius,
// index 1 atom_count; write only while idle.
// A load is written into the store when it is accepted. A query scans the
// slots from row i upward; each edge found stops the scan while the
// bit-serial square-root unit (21 steps) works out its distance, and the
// distance pipeline is refilled after each edge. An error row scans nothing.
// One item is handled at a time; in_ready is high only between items.
// A finished result sits in the output register; while the receiver stalls,
// the block keeps working until the next result needs that register.
// Reset clears control state, radius to 0 and atom_count to 1; the point
// store is not cleared and a slot must be loaded before it is read.
`default_nettype none

module radius_neighbor_edge_list_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [rnel_pkg::IDX_W-1:0]        in_atom_index,
  input  logic signed [rnel_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [rnel_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [rnel_pkg::COORD_W-1:0] in_coord_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rnel_pkg::IDX_W-1:0]        out_row_index,
  output logic [rnel_pkg::IDX_W-1:0]        out_col_index,
  output logic [rnel_pkg::DIST_W-1:0]       out_distance,
  output logic                              out_is_last,
  output logic                              out_row_error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rnel_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rnel_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rnel_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     j_r, j_nxt;
  logic [IDX_W-1:0]     row_r, row_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]     pend_col_r, pend_col_nxt;
  logic [DIST_W-1:0]    pend_dist_r, pend_dist_nxt;
  logic [IDX_W-1:0]     hcol_r, hcol_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_row_r, out_col_r;
  logic [DIST_W-1:0]    out_dist_r;
  logic                 out_last_r, out_err_r;
  logic [RAD_W-1:0]     radius_r;
  logic [CNT_REG_W-1:0] count_r;

  logic [CNT_W-1:0]     cnt_eff;
  logic                 row_bad, in_fits, out_free, hit, scan_end;
  logic                 push, push_last, push_err;
  logic [IDX_W-1:0]     push_col;
  logic [DIST_W-1:0]    push_dist;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_raddr, mem_waddr;
  point_t               mem_wdata, mem_rdata;
  scan_ctl_t            scan_ctl;
  scan_res_t            scan_res;
  logic                 sq_start;
  sqrt_stat_t           sq_stat;
  logic [DIST_W-1:0]    sq_root;

  rnel_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rnel_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (scan_ctl),
    .pt     (mem_rdata),
    .radius (radius_r),
    .res    (scan_res)
  );

  rnel_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (scan_res.d2),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  assign mem_waddr   = AW'(in_atom_index);
  assign mem_wdata.x = in_coord_x;
  assign mem_wdata.y = in_coord_y;
  assign mem_wdata.z = in_coord_z;

  always_comb begin
    cnt_eff  = (int'(count_r) > CNT_CAP) ? CNT_W'(CNT_CAP) : CNT_W'(count_r);
    row_bad  = CMP_W'(in_atom_index) >= CMP_W'(cnt_eff);
    in_fits  = int'(in_atom_index) < MAX_ATOMS;
    out_free = !out_valid_r || out_ready;
    hit      = scan_res.vld && scan_res.hit;
    scan_end = (j_r >= cnt_eff) && !scan_res.pend;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_QUERY) begin
          state_nxt = row_bad ? ST_ERR : ST_ROW;
        end
      end
      ST_ROW: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_SQRT;
        end else if (scan_end) begin
          state_nxt = ST_LAST;
        end
      end
      ST_SQRT: begin
        if (sq_stat.done && (!pend_v_r || out_free)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_LAST, ST_ERR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = AW'(in_atom_index);
    scan_ctl      = '0;
    sq_start      = 1'b0;
    push          = 1'b0;
    push_last     = 1'b0;
    push_err      = 1'b0;
    push_col      = pend_col_r;
    push_dist     = pend_dist_r;
    j_nxt         = j_r;
    row_nxt       = row_r;
    pend_v_nxt    = pend_v_r;
    pend_col_nxt  = pend_col_r;
    pend_dist_nxt = pend_dist_r;
    hcol_nxt      = hcol_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          row_nxt    = in_atom_index;
          j_nxt      = CNT_W'(in_atom_index);
          pend_v_nxt = 1'b0;
          if (in_action == ACT_LOAD) begin
            mem_we = in_fits;
          end else begin
            mem_re = 1'b1;
          end
        end
      end
      ST_ROW: begin
        scan_ctl.row_ld = 1'b1;
      end
      ST_SCAN: begin
        if (hit) begin
          scan_ctl.kill = 1'b1;
          sq_start      = 1'b1;
          hcol_nxt      = scan_res.col;
          j_nxt         = CNT_W'(scan_res.col) + CNT_W'(1);
        end else if (j_r < cnt_eff) begin
          mem_re       = 1'b1;
          mem_raddr    = AW'(j_r);
          scan_ctl.vld = 1'b1;
          scan_ctl.col = IDX_W'(j_r);
          j_nxt        = j_r + CNT_W'(1);
        end
      end
      ST_SQRT: begin
        // previous edge leaves while the root is worked out
        if (pend_v_r && out_free) begin
          push       = 1'b1;
          pend_v_nxt = 1'b0;
        end
        if (sq_stat.done && (!pend_v_r || out_free)) begin
          pend_v_nxt    = 1'b1;
          pend_col_nxt  = hcol_r;
          pend_dist_nxt = sq_root;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          push_err  = 1'b1;
          push_col  = '0;
          push_dist = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    pend_col_r  <= pend_col_nxt;
    pend_dist_r <= pend_dist_nxt;
    hcol_r      <= hcol_nxt;
    if (push) begin
      out_row_r  <= row_r;
      out_col_r  <= push_col;
      out_dist_r <= push_dist;
      out_last_r <= push_last;
      out_err_r  <= push_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      count_r  <= CNT_REG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIUS:     radius_r <= cfg_data[RAD_W-1:0];
        CFG_ATOM_COUNT: count_r  <= cfg_data[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_col_index = out_col_r;
  assign out_distance  = out_dist_r;
  assign out_is_last   = out_last_r;
  assign out_row_error = out_err_r;

endmodule

`default_nettype wire

/* rtl/rnel_checker.sv */
`default_nettype none
`include "radius_neighbor_edge_list_top_defines.svh"

module rnel_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [rnel_pkg::IDX_W-1:0]         out_row_index,
  input logic [rnel_pkg::IDX_W-1:0]         out_col_index,
  input logic [rnel_pkg::DIST_W-1:0]        out_distance,
  input logic                               out_is_last,
  input logic                               out_row_error
);
  import rnel_pkg::*;

  `RNEL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_row_index) && $stable(out_col_index) && $stable(out_distance) && $stable(out_is_last) && $stable(out_row_error), "result item changed while stalled")
  `RNEL_ASSERT_NOW(a_err_shape, clk, rst_n, out_valid && out_row_error, out_is_last && out_col_index == '0 && out_distance == '0, "error item malformed")
  `RNEL_ASSERT_NOW(a_col_order, clk, rst_n, out_valid && !out_row_error, out_col_index >= out_row_index, "edge column below row")
  `RNEL_ASSERT_NOW(a_self_zero, clk, rst_n, out_valid && !out_row_error && out_col_index == out_row_index, out_distance == '0, "self edge with nonzero distance")

endmodule

bind radius_neighbor_edge_list_top rnel_checker u_rnel_checker (.*);

`default_nettype wire

/* verif/radius_neighbor_edge_list_top_tb.sv */
`default_nettype none

module radius_neighbor_edge_list_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rnel_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;
  localparam logic [RAD_W-1:0]     RADIUS_MAX   = '1;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 60;

  typedef struct {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DIST_W-1:0] span;
    logic              last;
    logic              err;
  } nbr_edge_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_action;
  logic [IDX_W-1:0]          in_atom_index;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic signed [COORD_W-1:0] in_coord_z;
  logic                      out_valid;
  logic                      out_ready;
  logic [IDX_W-1:0]          out_row_index;
  logic [IDX_W-1:0]          out_col_index;
  logic [DIST_W-1:0]         out_distance;
  logic                      out_is_last;
  logic                      out_row_error;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  // local copy of the point store and registers
  logic signed [COORD_W-1:0] pos_x [MAX_ATOMS];
  logic signed [COORD_W-1:0] pos_y [MAX_ATOMS];
  logic signed [COORD_W-1:0] pos_z [MAX_ATOMS];
  logic [RAD_W-1:0]          radius_q;
  logic [CNT_REG_W-1:0]      count_q;

  nbr_edge_t pending_edges[$];
  int        mismatches;
  int        random_items;
  bit        steady;
  int        stall_left;

  radius_neighbor_edge_list_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_atom_index (in_atom_index),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_col_index (out_col_index),
    .out_distance  (out_distance),
    .out_is_last   (out_is_last),
    .out_row_error (out_row_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom);
  endfunction

  function automatic logic signed [COORD_W-1:0] near(input int c, input int spread);
    return COORD_W'(c + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic longint floor_root(input longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = 21; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void predict_row(input logic [IDX_W-1:0] row);
    int        eff;
    longint    rad;
    longint    lim2;
    longint    dx;
    longint    dy;
    longint    dz;
    longint    d2;
    nbr_edge_t hit;
    nbr_edge_t row_edges[$];
    eff = (count_q > CNT_CAP) ? CNT_CAP : count_q;
    if (row >= eff) begin
      hit.row  = row;
      hit.col  = '0;
      hit.span = '0;
      hit.last = 1'b1;
      hit.err  = 1'b1;
      pending_edges = {pending_edges, hit};
      return;
    end
    rad  = radius_q;
    lim2 = rad * rad;
    for (int j = row; j < eff; j++) begin
      dx = longint'(pos_x[row]) - longint'(pos_x[j]);
      dy = longint'(pos_y[row]) - longint'(pos_y[j]);
      dz = longint'(pos_z[row]) - longint'(pos_z[j]);
      d2 = dx * dx + dy * dy + dz * dz;
      if (d2 <= lim2) begin
        hit.row  = row;
        hit.col  = IDX_W'(j);
        hit.span = DIST_W'(floor_root(d2));
        hit.last = 1'b0;
        hit.err  = 1'b0;
        row_edges = {row_edges, hit};
      end
    end
    row_edges[row_edges.size() - 1].last = 1'b1;
    pending_edges = {pending_edges, row_edges};
  endfunction

  task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_atom_index <= idx;
    in_coord_x    <= x;
    in_coord_y    <= y;
    in_coord_z    <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ACT_LOAD) begin
      pos_x[idx] = x;
      pos_y[idx] = y;
      pos_z[idx] = z;
    end else begin
      predict_row(idx);
    end
  endtask

  task automatic query_row(input logic [IDX_W-1:0] row);
    send_item(ACT_QUERY, row, rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_edges.size() != 0 || !in_ready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_RADIUS:     radius_q = data[RAD_W-1:0];
      CFG_ATOM_COUNT: count_q  = data[CNT_REG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] rad,
                            input logic [CFG_DATA_W-1:0] cnt);
    settle();
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_ATOM_COUNT, cnt);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_edges
    nbr_edge_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_edges.size() == 0) begin
        $display("%0t: unexpected result, expected none, got row %0d col %0d", $time,
                 out_row_index, out_col_index);
        mismatches++;
      end else begin
        want = pending_edges.pop_front();
        check_field("row_index", want.row, out_row_index);
        check_field("col_index", want.col, out_col_index);
        check_field("distance", want.span, out_distance);
        check_field("is_last", want.last, out_is_last);
        check_field("row_error", want.err, out_row_error);
      end
    end
  end

  // defaults after reset: radius 0, one point
  task automatic test_reset_state();
    send_item(ACT_LOAD, 0, rand_coord(), rand_coord(), rand_coord());
    query_row(0);
    query_row(1);
    query_row(63);
  endtask

  task automatic test_fill_store();
    set_config(RADIUS_MAX, CFG_DATA_W'(CNT_CAP));
    for (int s = 0; s < MAX_ATOMS; s++) begin
      case (s)
        0, 2:    send_item(ACT_LOAD, IDX_W'(s), COORD_MIN, COORD_MIN, COORD_MIN);
        1:       send_item(ACT_LOAD, IDX_W'(s), COORD_MAX, COORD_MAX, COORD_MAX);
        3:       send_item(ACT_LOAD, IDX_W'(s), 1000, -2000, 3000);
        4:       send_item(ACT_LOAD, IDX_W'(s), 1300, -1600, 3000);
        default: send_item(ACT_LOAD, IDX_W'(s), rand_coord(), rand_coord(), rand_coord());
      endcase
    end
    query_row(0);
    query_row(63);
  endtask

  // slots 3 and 4 sit exactly 500 apart; slots 0 and 2 coincide
  task automatic test_radius_edge();
    set_config(500, CFG_DATA_W'(CNT_CAP));
    query_row(3);
    set_config(499, CFG_DATA_W'(CNT_CAP));
    query_row(3);
    set_config('0, CFG_DATA_W'(CNT_CAP));
    query_row(0);
    query_row(2);
  endtask

  task automatic test_count_limits();
    set_config(RADIUS_MAX, 0);
    query_row(0);
    query_row(63);
    set_config(RADIUS_MAX, 127);
    query_row(60);
    set_config(RADIUS_MAX, 65);
    query_row(63);
    settle();
    write_reg(CFG_ATOM_COUNT, 21'h1FFF85);
    query_row(5);
    query_row(4);
    settle();
    write_reg(CFG_UNUSED_2, '1);
    write_reg(CFG_UNUSED_3, '1);
    query_row(0);
  endtask

  task automatic test_random_graphs();
    int               kind;
    int               cnt;
    int               spread;
    int               loaded;
    int               n_items;
    int               cx;
    int               cy;
    int               cz;
    logic [RAD_W-1:0] rad;
    logic [IDX_W-1:0] slot;
    steady = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      kind   = $urandom_range(0, 9);
      spread = 1 << $urandom_range(3, 16);
      cx     = int'($urandom_range(0, 1 << 19)) - (1 << 18);
      cy     = int'($urandom_range(0, 1 << 19)) - (1 << 18);
      cz     = int'($urandom_range(0, 1 << 19)) - (1 << 18);
      if (kind == 0) begin
        cnt = $urandom_range(1, 16);
        rad = RAD_W'($urandom);
        loaded = cnt;
      end else if (kind == 1) begin
        cnt = $urandom_range(CNT_CAP, 127);
        rad = RAD_W'($urandom_range(spread, 3 * spread));
        loaded = 16;
      end else begin
        cnt = $urandom_range(2, 16);
        rad = RAD_W'($urandom_range(spread / 2, 3 * spread));
        loaded = cnt;
      end
      set_config(rad, CFG_DATA_W'(cnt));
      for (int s = 0; s < loaded; s++) begin
        if (kind == 0)
          send_item(ACT_LOAD, IDX_W'(s), rand_coord(), rand_coord(), rand_coord());
        else
          send_item(ACT_LOAD, IDX_W'(s), near(cx, spread), near(cy, spread),
                    near(cz, spread));
        random_items++;
      end
      n_items = $urandom_range(8, 20);
      repeat (n_items) begin
        if ($urandom_range(0, 9) == 0) settle();
        if ($urandom_range(0, 4) == 0) begin
          slot = IDX_W'($urandom);
          if (kind == 0)
            send_item(ACT_LOAD, slot, rand_coord(), rand_coord(), rand_coord());
          else
            send_item(ACT_LOAD, slot, near(cx, spread), near(cy, spread),
                      near(cz, spread));
        end else begin
          if ($urandom_range(0, 7) == 0) slot = IDX_W'($urandom);
          else slot = IDX_W'($urandom_range(0, loaded - 1));
          query_row(slot);
        end
        random_items++;
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = ACT_LOAD;
    in_atom_index = '0;
    in_coord_x    = '0;
    in_coord_y    = '0;
    in_coord_z    = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_RADIUS;
    cfg_data      = '0;
    radius_q      = '0;
    count_q       = 1;
    mismatches    = 0;
    random_items  = 0;
    steady        = 1'b0;
    stall_left    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_fill_store();
    test_radius_edge();
    test_count_limits();
    test_random_graphs();
    settle();

    if (mismatches == 0 && pending_edges.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
